// File: design/bspsc_pkg.sv
// Shared widths, queue depths and queue entry types for the bubble sort block.
package bspsc_pkg;

	localparam int VAL_W            = 32;
	localparam int IDX_W            = 6;
	localparam int SWP_W            = 6;
	localparam int MAX_ELEMENTS_DEF = 16;
	localparam int CMD_DEPTH        = 4;
	localparam int RES_DEPTH        = 4;

	// Classified input request, front to back.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    store;
		logic                    last;
		logic                    ovf;
	} cmd_t;

	// One result waiting in the output queue.
	typedef struct packed {
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] sorted_value;
		logic [SWP_W-1:0]        pass_swaps;
		logic                    overflow;
		logic                    end_of_run;
	} res_t;

endpackage

// File: design/bspsc_ram.sv
// Generic one-write one-read RAM with registered read data.
module bspsc_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/bspsc_fifo.sv
// Small synchronous FIFO with occupancy count.
module bspsc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               din,
	output logic                       full,
	input  logic                       pop,
	output logic [W-1:0]               dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/bspsc_front.sv
// Input side: counts loaded elements, marks drops at capacity, queues requests.
module bspsc_front #(
	parameter int MAX_ELEMENTS = bspsc_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [bspsc_pkg::VAL_W-1:0] value,
	input  logic                              last,
	input  logic                              cmd_full,
	output logic                              cmd_push,
	output bspsc_pkg::cmd_t                   cmd
);

	localparam int NW = $clog2(MAX_ELEMENTS+1);

	logic [NW-1:0] cnt_q;
	logic          ovf_q;
	logic          store;

	assign full      = cmd_full;
	assign cmd_push  = push && !cmd_full;
	assign store     = (cnt_q != NW'(MAX_ELEMENTS));
	assign cmd.value = value;
	assign cmd.store = store;
	assign cmd.last  = last;
	assign cmd.ovf   = ovf_q || !store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd_push) begin
			if (last) begin
				// run closes here; next request starts a fresh load
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (store) begin
				cnt_q <= cnt_q + NW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

// File: design/bspsc_back.sv
// Sort engine: loads the element RAM, runs bubble passes, streams results out.
module bspsc_back #(
	parameter int MAX_ELEMENTS = bspsc_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cmd_empty,
	output logic                                        cmd_pop,
	input  bspsc_pkg::cmd_t                             cmd,
	output logic                                        res_push,
	output bspsc_pkg::res_t                             res,
	input  logic [$clog2(bspsc_pkg::RES_DEPTH+1)-1:0]   res_count
);

	localparam int AW  = $clog2(MAX_ELEMENTS);
	localparam int NW  = $clog2(MAX_ELEMENTS+1);
	localparam int CW  = $clog2(bspsc_pkg::RES_DEPTH+1) + 1;
	localparam int VW  = bspsc_pkg::VAL_W;
	localparam int SW  = bspsc_pkg::SWP_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN,
		ST_TAIL,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [NW-1:0]         ld_q, n_q, len_q;
	logic                  ovf_q;
	logic [AW-1:0]         k_q, pass_q, e_q, infl_idx_q;
	logic signed [VW-1:0]  carry_q;
	logic [SW-1:0]         swaps_q;
	logic                  infl_q, infl_last_q;

	logic                  st_we;
	logic [AW-1:0]         st_waddr, st_raddr;
	logic signed [VW-1:0]  st_wdata, rd_data;
	logic [SW-1:0]         swp_rd;

	logic [NW-1:0]         lm1, nm1, n_next;
	logic                  gt, credit, emit_issue, e_last;

	assign lm1        = len_q - NW'(1);
	assign nm1        = n_q - NW'(1);
	assign n_next     = ld_q + NW'(cmd.store);
	assign gt         = carry_q > rd_data;
	assign credit     = (CW'(res_count) + CW'(infl_q)) < CW'(bspsc_pkg::RES_DEPTH);
	assign emit_issue = (state_q == ST_EMIT) && credit;
	assign e_last     = (e_q == nm1[AW-1:0]);
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty;

	// one read and one write per cycle: the larger value rides along in carry_q
	always_comb begin
		st_we    = 1'b0;
		st_waddr = ld_q[AW-1:0];
		st_wdata = cmd.value;
		st_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				st_we = cmd_pop && cmd.store;
			end
			ST_PRIME: begin
				st_raddr = AW'(1);
			end
			ST_RUN: begin
				st_we    = 1'b1;
				st_waddr = k_q - AW'(1);
				st_wdata = gt ? rd_data : carry_q;
				st_raddr = k_q + AW'(1);
			end
			ST_TAIL: begin
				st_we    = 1'b1;
				st_waddr = lm1[AW-1:0];
				st_wdata = carry_q;
			end
			ST_EMIT: begin
				st_raddr = e_q;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	bspsc_ram #(.W(VW), .DEPTH(MAX_ELEMENTS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (rd_data)
	);

	bspsc_ram #(.W(SW), .DEPTH(MAX_ELEMENTS)) u_swaps (
		.clk   (clk),
		.we    (state_q == ST_TAIL),
		.waddr (pass_q),
		.wdata (swaps_q),
		.raddr (e_q),
		.rdata (swp_rd)
	);

	assign res_push           = infl_q;
	assign res.index          = bspsc_pkg::IDX_W'(infl_idx_q);
	assign res.sorted_value   = rd_data;
	assign res.pass_swaps     = infl_last_q ? '0 : swp_rd;
	assign res.overflow       = ovf_q;
	assign res.end_of_run     = infl_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ld_q        <= '0;
			n_q         <= '0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			pass_q      <= '0;
			e_q         <= '0;
			infl_idx_q  <= '0;
			carry_q     <= '0;
			swaps_q     <= '0;
			infl_q      <= 1'b0;
			infl_last_q <= 1'b0;
		end else begin
			infl_q <= emit_issue;
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.last) begin
							ld_q    <= '0;
							n_q     <= n_next;
							len_q   <= n_next;
							ovf_q   <= cmd.ovf;
							pass_q  <= '0;
							e_q     <= '0;
							state_q <= (n_next >= NW'(2)) ? ST_PRIME : ST_EMIT;
						end else if (cmd.store) begin
							ld_q <= ld_q + NW'(1);
						end
					end
				end
				ST_PRIME: begin
					carry_q <= rd_data;
					k_q     <= AW'(1);
					swaps_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					carry_q <= gt ? carry_q : rd_data;
					swaps_q <= swaps_q + SW'(gt);
					if (k_q == lm1[AW-1:0]) begin
						state_q <= ST_TAIL;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				ST_TAIL: begin
					len_q   <= lm1;
					pass_q  <= pass_q + AW'(1);
					state_q <= (lm1 >= NW'(2)) ? ST_PRIME : ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_issue) begin
						infl_last_q <= e_last;
						infl_idx_q  <= e_q;
						e_q         <= e_q + AW'(1);
						if (e_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/bubble_sort_pass_swap_count_top.sv
// Top level of the bubble sort block with per-pass swap counts.
// Elements are pushed one per cycle into a four-entry request queue; the front
// keeps taking elements, also for the next run, until that queue is full. Once
// the last element reaches the sort engine, the run is sorted in bubble passes,
// each pass running on the single read and single write port of the element
// RAM, and then the results stream into a four-entry result queue. No clearing
// pass follows reset; the block takes requests as soon as reset is released.
module bubble_sort_pass_swap_count_top #(
	parameter int MAX_ELEMENTS = bspsc_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [bspsc_pkg::VAL_W-1:0] value,
	input  logic                               last,
	output logic                               empty,
	input  logic                               pop,
	output logic [bspsc_pkg::IDX_W-1:0]        index,
	output logic signed [bspsc_pkg::VAL_W-1:0] sorted_value,
	output logic [bspsc_pkg::SWP_W-1:0]        pass_swaps,
	output logic                               overflow,
	output logic                               end_of_run
);

	localparam int CMD_W = $bits(bspsc_pkg::cmd_t);
	localparam int RES_W = $bits(bspsc_pkg::res_t);

	bspsc_pkg::cmd_t cmd_in, cmd_out;
	bspsc_pkg::res_t res_in, res_out;
	logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic            res_push;
	logic [$clog2(bspsc_pkg::RES_DEPTH+1)-1:0] res_count;

	bspsc_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.last     (last),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	bspsc_fifo #(.W(CMD_W), .DEPTH(bspsc_pkg::CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty),
		.count  ()
	);

	bspsc_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_out),
		.res_push  (res_push),
		.res       (res_in),
		.res_count (res_count)
	);

	// the back end only issues reads it has room for, so full is never hit
	bspsc_fifo #(.W(RES_W), .DEPTH(bspsc_pkg::RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty),
		.count  (res_count)
	);

	assign index        = res_out.index;
	assign sorted_value = res_out.sorted_value;
	assign pass_swaps   = res_out.pass_swaps;
	assign overflow     = res_out.overflow;
	assign end_of_run   = res_out.end_of_run;

endmodule

// File: design/bspsc_checker.sv
// Port-level assertions for the bubble sort top level, attached by bind.
module bspsc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               empty,
	input logic                               pop,
	input logic [bspsc_pkg::IDX_W-1:0]        index,
	input logic signed [bspsc_pkg::VAL_W-1:0] sorted_value,
	input logic [bspsc_pkg::SWP_W-1:0]        pass_swaps,
	input logic                               overflow,
	input logic                               end_of_run
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(index) && $stable(sorted_value)
			&& $stable(pass_swaps) && $stable(overflow) && $stable(end_of_run)))
		else $error("result changed while stalled");

	// pass i of an n-element run swaps at most n-1-i times; checked here only as index plus swap count below 64
	a_swap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, index} + {1'b0, pass_swaps}) < 7'd64)
		else $error("pass swap count too large for its index");

	// next result of the same run: index steps by one, value does not drop
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !end_of_run) ##1 !empty |->
			(index == $past(index) + 6'd1)
			&& ($signed(sorted_value) >= $signed($past(sorted_value))))
		else $error("results out of order within a run");

	// overflow flag is the same on every result of a run
	a_ovf_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !end_of_run) ##1 !empty |-> overflow == $past(overflow))
		else $error("overflow flag changed within a run");

endmodule

bind bubble_sort_pass_swap_count_top bspsc_checker u_bspsc_checker (.*);
